// ===== hw/rtl/fclip_pkg.sv =====
package fclip_pkg;

  localparam int MAX_POLY_VERTS = 9;
  localparam int COORD_W        = 32;
  localparam int T_FRAC         = 16;
  localparam int NUM_PLANES     = 6;
  localparam int CHAIN_DEPTH    = 2 * MAX_POLY_VERTS;
  localparam int CHAIN_CNT_W    = $clog2(CHAIN_DEPTH + 1);
  localparam int VCNT_W         = $clog2(MAX_POLY_VERTS + 1);
  localparam int TOL_W          = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W+2:0] wide_t;   // plane numerators and denominators
  typedef logic [COORD_W+1:0]        mag_t;    // their magnitudes
  typedef logic [T_FRAC:0]           tval_t;   // unsigned Q1.16
  typedef logic [T_FRAC-1:0]         quot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } vert_t;

  typedef enum logic [2:0] {
    PL_TOP    = 3'd0,
    PL_BOTTOM = 3'd1,
    PL_RIGHT  = 3'd2,
    PL_LEFT   = 3'd3,
    PL_FAR    = 3'd4,
    PL_NEAR   = 3'd5
  } plane_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLASSIFY, S_PASS, S_REJECT, S_LOAD, S_PLANE, S_POP, S_TEST,
    S_NUMDEN, S_GUARD, S_DIV, S_MUL, S_ADD, S_PUSH_X, S_PUSH_CUR, S_NEXT,
    S_PLANE_END, S_FAN, S_EMPTY, S_FAN0, S_FAN1, S_FAN_A, S_FAN_B, S_FAN_C
  } state_t;

  function automatic wide_t ext(coord_t c);
    return wide_t'(c);
  endfunction

  function automatic logic is_out(vert_t v, plane_t p);
    logic r;
    case (p)
      PL_TOP:    r = ext(v.y) > ext(v.w);
      PL_BOTTOM: r = ext(v.y) < -ext(v.w);
      PL_RIGHT:  r = ext(v.x) > ext(v.w);
      PL_LEFT:   r = ext(v.x) < -ext(v.w);
      PL_FAR:    r = ext(v.z) > ext(v.w);
      default:   r = v.z < 0;
    endcase
    return r;
  endfunction

  function automatic logic [NUM_PLANES-1:0] outcode(vert_t v);
    logic [NUM_PLANES-1:0] c;
    for (int i = 0; i < NUM_PLANES; i++) begin
      c[i] = is_out(v, plane_t'(i));
    end
    return c;
  endfunction

  function automatic coord_t coord_of(vert_t v, logic [1:0] k);
    coord_t c;
    case (k)
      2'd0:    c = v.x;
      2'd1:    c = v.y;
      2'd2:    c = v.z;
      default: c = v.w;
    endcase
    return c;
  endfunction

  function automatic mag_t mag_of(wide_t v);
    wide_t a;
    a = v[COORD_W+2] ? -v : v;
    return a[COORD_W+1:0];
  endfunction

endpackage

// ===== hw/rtl/fclip_cell.sv =====
module fclip_cell (
  input  logic                clk,
  input  logic                shift_en,
  input  logic                load_en,
  input  fclip_pkg::vert_t    neighbor,
  input  fclip_pkg::vert_t    bus,
  output fclip_pkg::vert_t    q
);
  import fclip_pkg::*;

  always_ff @(posedge clk) begin
    if (load_en) begin
      q <= bus;
    end else if (shift_en) begin
      q <= neighbor;
    end
  end

endmodule

// ===== hw/rtl/fclip_chain.sv =====
module fclip_chain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                push,
  input  fclip_pkg::vert_t                    push_data,
  input  logic                                pop,
  output fclip_pkg::vert_t                    head
);
  import fclip_pkg::*;

  vert_t q [CHAIN_DEPTH];
  vert_t nb [CHAIN_DEPTH];
  logic [CHAIN_CNT_W-1:0] count;

  for (genvar i = 0; i < CHAIN_DEPTH; i++) begin : g_cell
    if (i == CHAIN_DEPTH - 1) begin : g_end
      assign nb[i] = q[i];
    end else begin : g_mid
      assign nb[i] = q[i+1];
    end
    fclip_cell u_cell (
      .clk      (clk),
      .shift_en (pop),
      .load_en  (push && (count == CHAIN_CNT_W'(i))),
      .neighbor (nb[i]),
      .bus      (push_data),
      .q        (q[i])
    );
  end

  assign head = q[0];

  // push and pop never fall in the same cycle
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (push) begin
      count <= count + 1'b1;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/fclip_div.sv =====
module fclip_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fclip_pkg::mag_t      num,
  input  fclip_pkg::mag_t      den,
  output logic                 done,
  output fclip_pkg::quot_t     quot
);
  import fclip_pkg::*;

  localparam int STEP_W = $clog2(T_FRAC);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [COORD_W+2:0]    rem;
  mag_t                  dsr;
  logic [COORD_W+2:0]    rem2;
  logic                  fits;

  assign rem2 = {rem[COORD_W+1:0], 1'b0};
  assign fits = rem2 >= {1'b0, dsr};

  // one quotient bit per cycle, numerator below denominator on entry
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(T_FRAC - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dsr  <= den;
      step <= '0;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? rem2 - {1'b0, dsr} : rem2;
      quot <= {quot[T_FRAC-2:0], fits};
      step <= step + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/frustum_triangle_clipper.sv =====
// Pass-through gives its three vertices, one per cycle while the output is not stalled.
// Reject gives a single marker result.
// Clipping walks the polygon once per plane; each crossing edge passes through the 16-step
// divider (unless the guard settles t) and the shared multiplier, one coordinate at a time.
// One triangle at a time; a new one is taken once its last result is loaded for output.
// rst clears control state and sets the tolerance register tol to 1; vertex cells are not reset.
module frustum_triangle_clipper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [fclip_pkg::TOL_W-1:0]     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fclip_pkg::coord_t               v0_x,
  input  fclip_pkg::coord_t               v0_y,
  input  fclip_pkg::coord_t               v0_z,
  input  fclip_pkg::coord_t               v0_w,
  input  fclip_pkg::coord_t               v1_x,
  input  fclip_pkg::coord_t               v1_y,
  input  fclip_pkg::coord_t               v1_z,
  input  fclip_pkg::coord_t               v1_w,
  input  fclip_pkg::coord_t               v2_x,
  input  fclip_pkg::coord_t               v2_y,
  input  fclip_pkg::coord_t               v2_z,
  input  fclip_pkg::coord_t               v2_w,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fclip_pkg::coord_t               out_x,
  output fclip_pkg::coord_t               out_y,
  output fclip_pkg::coord_t               out_z,
  output fclip_pkg::coord_t               out_w,
  output logic [1:0]                      corner,
  output logic                            has_vertex,
  output logic                            accepted,
  output logic                            last
);
  import fclip_pkg::*;

  localparam int PROD_W = COORD_W + T_FRAC + 3;
  localparam int RND_W  = COORD_W + 4;

  state_t               state, state_next;
  logic [TOL_W-1:0]     tol;
  vert_t                vin [3];
  logic [1:0]           idx;
  plane_t               plane;
  logic [VCNT_W-1:0]    n, m, j, fan_i;
  vert_t                prev, cur, xv, last_pushed;
  wide_t                num, den;
  logic                 near_zero;
  tval_t                t;
  logic [1:0]           k;
  logic signed [PROD_W-1:0] prod;
  logic                 cin;

  // chain and divider hookups
  logic                 ch_clear, ch_push, ch_pop;
  vert_t                ch_data, ch_head;
  logic                 div_start, div_done;
  quot_t                div_q;
  mag_t                 mn, md;

  // output register load
  logic                 out_free, out_load;
  vert_t                ov_next;
  logic [1:0]           corner_next;
  logic                 hv_next, acc_next, last_next;

  logic [NUM_PLANES-1:0] c0, c1, c2;
  logic                 room, guard_zero;

  fclip_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .clear     (ch_clear),
    .push      (ch_push),
    .push_data (ch_data),
    .pop       (ch_pop),
    .head      (ch_head)
  );

  fclip_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mn),
    .den   (md),
    .done  (div_done),
    .quot  (div_q)
  );

  assign c0 = outcode(vin[0]);
  assign c1 = outcode(vin[1]);
  assign c2 = outcode(vin[2]);
  assign room = m < VCNT_W'(MAX_POLY_VERTS);
  assign mn = mag_of(num);
  assign md = mag_of(den);
  assign guard_zero = near_zero || den == '0 ||
                      (num != '0 && (num[COORD_W+2] != den[COORD_W+2]));
  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next  = state;
    ch_clear    = 1'b0;
    ch_push     = 1'b0;
    ch_pop      = 1'b0;
    ch_data     = cur;
    div_start   = 1'b0;
    out_load    = 1'b0;
    ov_next     = '0;
    corner_next = '0;
    hv_next     = 1'b1;
    acc_next    = 1'b1;
    last_next   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        ch_clear = 1'b1;
        if ((c0 | c1 | c2) == '0) begin
          state_next = S_PASS;
        end else if ((c0 & c1 & c2) != '0) begin
          state_next = S_REJECT;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_PASS: begin
        ov_next     = vin[idx];
        corner_next = idx;
        last_next   = idx == 2'd2;
        if (out_free) begin
          out_load = 1'b1;
          if (idx == 2'd2) begin
            state_next = S_IDLE;
          end
        end
      end
      S_REJECT: begin
        hv_next   = 1'b0;
        acc_next  = 1'b0;
        last_next = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        ch_push = 1'b1;
        ch_data = vin[idx];
        if (idx == 2'd2) begin
          state_next = S_PLANE;
        end
      end
      S_PLANE: begin
        state_next = (n == '0) ? S_PLANE_END : S_POP;
      end
      S_POP: begin
        ch_pop     = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (cin != !is_out(prev, plane)) begin
          state_next = S_NUMDEN;
        end else if (cin) begin
          state_next = S_PUSH_CUR;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NUMDEN: state_next = S_GUARD;
      S_GUARD: begin
        if (guard_zero || mn >= md) begin
          state_next = S_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = (k == 2'd3) ? S_PUSH_X : S_MUL;
      S_PUSH_X: begin
        ch_push    = room;
        ch_data    = xv;
        state_next = cin ? S_PUSH_CUR : S_NEXT;
      end
      S_PUSH_CUR: begin
        ch_push    = room;
        ch_data    = cur;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = (j + 1'b1 == n) ? S_PLANE_END : S_POP;
      end
      S_PLANE_END: begin
        state_next = (plane == PL_NEAR) ? S_FAN : S_PLANE;
      end
      S_FAN: begin
        state_next = (n < VCNT_W'(3)) ? S_EMPTY : S_FAN0;
      end
      S_EMPTY: begin
        hv_next   = 1'b0;
        last_next = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FAN0: begin
        ch_pop     = 1'b1;
        state_next = S_FAN1;
      end
      S_FAN1: begin
        ch_pop     = 1'b1;
        state_next = S_FAN_A;
      end
      S_FAN_A: begin
        ov_next = xv;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_FAN_B;
        end
      end
      S_FAN_B: begin
        ov_next     = prev;
        corner_next = 2'd1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_FAN_C;
        end
      end
      S_FAN_C: begin
        ov_next     = ch_head;
        corner_next = 2'd2;
        last_next   = fan_i + VCNT_W'(2) == n;
        if (out_free) begin
          out_load   = 1'b1;
          ch_pop     = 1'b1;
          state_next = last_next ? S_IDLE : S_FAN_A;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(1);
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x      <= ov_next.x;
      out_y      <= ov_next.y;
      out_z      <= ov_next.z;
      out_w      <= ov_next.w;
      corner     <= corner_next;
      has_vertex <= hv_next;
      accepted   <= acc_next;
      last       <= last_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    wide_t                    dz;
    logic signed [COORD_W:0]  diff;
    logic [PROD_W-1:0]        pmag;
    logic [RND_W-1:0]         rmag;
    logic signed [RND_W:0]    rsum;
    coord_t                   rsat;
    dz   = ext(prev.z) - ext(cur.z);
    diff = (COORD_W+1)'(coord_of(cur, k)) - (COORD_W+1)'(coord_of(prev, k));
    pmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    rmag = RND_W'((pmag + PROD_W'(1 << (T_FRAC - 1))) >> T_FRAC);
    rsum = (RND_W+1)'(coord_of(prev, k)) +
           (prod[PROD_W-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag}));
    if (rsum > (RND_W+1)'(coord_t'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      rsat = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (rsum < (RND_W+1)'(coord_t'({1'b1, {(COORD_W-1){1'b0}}}))) begin
      rsat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      rsat = rsum[COORD_W-1:0];
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          vin[0] <= '{x: v0_x, y: v0_y, z: v0_z, w: v0_w};
          vin[1] <= '{x: v1_x, y: v1_y, z: v1_z, w: v1_w};
          vin[2] <= '{x: v2_x, y: v2_y, z: v2_z, w: v2_w};
        end
        idx <= '0;
      end
      S_CLASSIFY: begin
        idx   <= '0;
        plane <= PL_TOP;
        n     <= VCNT_W'(3);
      end
      S_PASS: begin
        if (out_free) begin
          idx <= idx + 1'b1;
        end
      end
      S_LOAD: begin
        last_pushed <= vin[idx];
        idx         <= idx + 1'b1;
      end
      S_PLANE: begin
        prev <= last_pushed;
        j    <= '0;
        m    <= '0;
      end
      S_POP: begin
        cur <= ch_head;
        cin <= !is_out(ch_head, plane);
      end
      S_NUMDEN: begin
        near_zero <= 1'b0;
        case (plane)
          PL_TOP: begin
            num <= ext(prev.w) - ext(prev.y);
            den <= (ext(cur.y) - ext(prev.y)) - (ext(cur.w) - ext(prev.w));
          end
          PL_BOTTOM: begin
            num <= ext(prev.w) + ext(prev.y);
            den <= (ext(prev.w) + ext(prev.y)) - (ext(cur.w) + ext(cur.y));
          end
          PL_RIGHT: begin
            num <= ext(prev.w) - ext(prev.x);
            den <= (ext(cur.x) - ext(prev.x)) - (ext(cur.w) - ext(prev.w));
          end
          PL_LEFT: begin
            num <= ext(prev.w) + ext(prev.x);
            den <= (ext(prev.w) + ext(prev.x)) - (ext(cur.w) + ext(cur.x));
          end
          PL_FAR: begin
            num <= ext(prev.w) - ext(prev.z);
            den <= (ext(cur.z) - ext(prev.z)) - (ext(cur.w) - ext(prev.w));
          end
          default: begin
            num       <= -ext(prev.z);
            den       <= ext(cur.z) - ext(prev.z);
            near_zero <= mag_of(dz) < mag_t'(tol);
          end
        endcase
      end
      S_GUARD: begin
        k <= '0;
        if (guard_zero) begin
          t <= '0;
        end else begin
          t <= tval_t'(1 << T_FRAC);
        end
      end
      S_DIV: begin
        if (div_done) begin
          t <= {1'b0, div_q};
        end
      end
      S_MUL: begin
        prod <= PROD_W'(diff * $signed({1'b0, t}));
      end
      S_ADD: begin
        case (k)
          2'd0:    xv.x <= rsat;
          2'd1:    xv.y <= rsat;
          2'd2:    xv.z <= rsat;
          default: xv.w <= rsat;
        endcase
        k <= k + 1'b1;
      end
      S_PUSH_X: begin
        if (room) begin
          last_pushed <= xv;
          m           <= m + 1'b1;
        end
      end
      S_PUSH_CUR: begin
        if (room) begin
          last_pushed <= cur;
          m           <= m + 1'b1;
        end
      end
      S_NEXT: begin
        prev <= cur;
        j    <= j + 1'b1;
      end
      S_PLANE_END: begin
        n     <= m;
        plane <= plane_t'(plane + 1'b1);
      end
      S_FAN0: begin
        xv <= ch_head;
      end
      S_FAN1: begin
        prev  <= ch_head;
        fan_i <= VCNT_W'(1);
      end
      S_FAN_C: begin
        if (out_free) begin
          prev  <= ch_head;
          fan_i <= fan_i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/fclip_checker.sv =====
module fclip_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input fclip_pkg::coord_t     out_x,
  input logic [1:0]            corner,
  input logic                  has_vertex,
  input logic                  accepted,
  input logic                  last
);
  import fclip_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(last))
    else $error("result changed while stalled");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_vertex |-> last && corner == 2'd0)
    else $error("marker result is not the final one");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !has_vertex)
    else $error("rejected item carries a vertex");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_vertex && last |-> corner == 2'd2)
    else $error("triangle fan ends mid triangle");

endmodule

bind frustum_triangle_clipper fclip_checker u_fclip_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_x      (out_x),
  .corner     (corner),
  .has_vertex (has_vertex),
  .accepted   (accepted),
  .last       (last)
);
